// ===== rtl/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VALUE_W      = 32;
	localparam int PRIO_W       = 8;
	localparam int OCC_W        = 5;

	typedef enum logic [0:0] {
		FN_ENQ = 1'b0,
		FN_DEQ = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic        [PRIO_W-1:0]  prio;
	} entry_t;

	// broadcast to every cell
	typedef struct packed {
		logic   enq;
		logic   deq;
		entry_t ins;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/spq_if.sv =====
`default_nettype none

interface spq_in_if import spq_pkg::*; ();
	logic                      valid;
	logic                      ready;
	func_t                     func;
	logic signed [VALUE_W-1:0] item_value;
	logic        [PRIO_W-1:0]  item_priority;

	modport source (output valid, func, item_value, item_priority, input ready);
	modport sink   (input valid, func, item_value, item_priority, output ready);
endinterface

interface spq_out_if import spq_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] out_value;
	logic        [PRIO_W-1:0]  out_priority;
	status_t                   status;
	logic        [OCC_W-1:0]   occupancy;

	modport source (output valid, out_value, out_priority, status, occupancy, input ready);
	modport sink   (input valid, out_value, out_priority, status, occupancy, output ready);
endinterface

`default_nettype wire

// ===== rtl/spq_cell.sv =====
`default_nettype none

module spq_cell import spq_pkg::*; #(
	parameter int CNT_W = 5,
	parameter int IDX   = 0
) (
	input  wire logic             clk,
	input  wire cell_ctl_t        ctl,
	input  wire logic [CNT_W-1:0] count,
	input  wire logic             left_ge,
	input  wire entry_t           left_entry,
	input  wire entry_t           right_entry,
	output      logic             ge,
	output      entry_t           entry
);

	entry_t entry_q;
	logic   occupied;

	assign occupied = CNT_W'(IDX) < count;
	// held entry stays ahead of the new one
	assign ge       = occupied && (entry_q.prio >= ctl.ins.prio);
	assign entry    = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.enq && !ge) begin
			entry_q <= left_ge ? ctl.ins : left_entry;
		end else if (ctl.deq) begin
			entry_q <= right_entry;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// Response is registered: valid in the cycle after the request transfer.
// Throughput: one item per cycle unless the response side stalls; every cell
//   compares and shifts in parallel; the response register refills as taken.
// Reset (arst_n low, asynchronous): occupancy to zero, response register empty.
//   Entry storage is not cleared; slots at or above the count are never read.
`default_nettype none

module sorted_priority_queue import spq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	spq_in_if.sink   req,
	spq_out_if.source rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             rsp_valid_q;
	entry_t           rsp_entry_q;
	status_t          rsp_status_q;
	logic [OCC_W-1:0] rsp_occ_q;

	logic      accept;
	logic      full;
	logic      empty;
	cell_ctl_t ctl;
	status_t   status_nxt;
	entry_t    result_nxt;

	logic   ge  [CAPACITY];
	entry_t ent [CAPACITY];

	// Take a new request whenever the response slot is free or draining.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign full  = count_q == CNT_W'(CAPACITY);
	assign empty = count_q == '0;

	// Gate shifts so a dropped enqueue or an empty dequeue leaves the row alone.
	assign ctl.enq        = accept && (req.func == FN_ENQ) && !full;
	assign ctl.deq        = accept && (req.func == FN_DEQ) && !empty;
	assign ctl.ins.value  = req.item_value;
	assign ctl.ins.prio   = req.item_priority;

	// Row of cells, highest priority at index 0. On insert, each cell keeps,
	// takes the new entry (first cell whose left neighbor is ahead), or takes
	// its left neighbor. On remove, each cell takes its right neighbor.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic   left_ge;
		entry_t left_entry;
		entry_t right_entry;

		if (i == 0) begin : g_head
			assign left_ge    = 1'b1;
			assign left_entry = ctl.ins;
		end else begin : g_body
			assign left_ge    = ge[i-1];
			assign left_entry = ent[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_entry = ent[i];
		end else begin : g_mid
			assign right_entry = ent[i+1];
		end

		spq_cell #(
			.CNT_W (CNT_W),
			.IDX   (i)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.count       (count_q),
			.left_ge     (left_ge),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.ge          (ge[i]),
			.entry       (ent[i])
		);
	end

	always_comb begin
		count_nxt  = count_q;
		result_nxt = '0;
		if (req.func == FN_ENQ) begin
			if (full) begin
				status_nxt = ST_FULL;
			end else begin
				status_nxt = ST_INSERTED;
				count_nxt  = count_q + 1'b1;
			end
		end else begin
			if (empty) begin
				status_nxt = ST_EMPTY;
			end else begin
				status_nxt = ST_REMOVED;
				result_nxt = ent[0];
				count_nxt  = count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_entry_q  <= result_nxt;
			rsp_status_q <= status_nxt;
			rsp_occ_q    <= OCC_W'(count_nxt);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.out_value    = rsp_entry_q.value;
	assign rsp.out_priority = rsp_entry_q.prio;
	assign rsp.status       = rsp_status_q;
	assign rsp.occupancy    = rsp_occ_q;

	// Assertions

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("occupancy beyond capacity");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("occupancy changed without a transfer");

	a_insert_status: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.func == FN_ENQ && !full) |=>
			(rsp.valid && rsp.status == ST_INSERTED && count_q == $past(count_q) + 1'b1))
		else $error("insert not reported");

	a_remove_head: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.func == FN_DEQ && !empty) |=>
			(rsp.status == ST_REMOVED && rsp.out_priority == $past(ent[0].prio)))
		else $error("remove did not return head entry");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none

module testbench;
	import spq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_ITEMS  = 1000;
	localparam int PHASE_LEN   = 50;

	// one response as the block reports it
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic        [PRIO_W-1:0]  prio;
		status_t                   status;
		logic        [OCC_W-1:0]   occ;
	} result_t;

	// directed stimulus row; reps > 1 repeats the request with stepped value/priority
	typedef struct {
		func_t                     op;
		logic signed [VALUE_W-1:0] value;
		logic        [PRIO_W-1:0]  prio;
		int                        reps;
		bit                        pinned;
		result_t                   want;
	} row_t;

	// per-transfer override: a typed-in answer takes the place of the prediction
	typedef struct {
		bit      pinned;
		result_t want;
	} pin_t;

	logic clk;
	logic arst_n;

	spq_in_if  req_if ();
	spq_out_if rsp_if ();

	sorted_priority_queue #(.CAPACITY(CAPACITY_DEF)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	// shadow of the queue contents, highest priority at index 0
	logic signed [VALUE_W-1:0] held_value [CAPACITY_DEF];
	logic        [PRIO_W-1:0]  held_prio  [CAPACITY_DEF];
	int                        held;

	result_t pending_q [$];   // responses still owed by the block
	pin_t    pin_q     [$];   // one per queued request, in send order

	int  errors;
	int  cycles;
	int  sent;
	int  seen_status [4];
	bit  calm;                // when set, neither side inserts gaps

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d responses outstanding", $realtime, pending_q.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Sorted insert behind all entries of equal or higher priority, so ties
	// leave in arrival order. Dequeue pops the head and shifts the rest up.
	function automatic result_t apply_item(func_t op, logic signed [VALUE_W-1:0] v,
			logic [PRIO_W-1:0] p);
		result_t r;
		int      pos;
		int      i;
		r = '0;
		if (op == FN_ENQ) begin
			if (held >= CAPACITY_DEF) begin
				r.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < held && held_prio[pos] >= p)
					pos++;
				for (i = held; i > pos; i--) begin
					held_value[i] = held_value[i-1];
					held_prio[i]  = held_prio[i-1];
				end
				held_value[pos] = v;
				held_prio[pos]  = p;
				held++;
				r.status = ST_INSERTED;
			end
		end else begin
			if (held == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.value = held_value[0];
				r.prio  = held_prio[0];
				for (i = 0; i + 1 < held; i++) begin
					held_value[i] = held_value[i+1];
					held_prio[i]  = held_prio[i+1];
				end
				held--;
				r.status = ST_REMOVED;
			end
		end
		r.occ = OCC_W'(held);
		return r;
	endfunction

	// mostly back-to-back, some short gaps, rare long ones
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Scoreboard. Request side first so a same-edge response would still find
	// its prediction queued.
	always @(posedge clk) begin
		pin_t    pin;
		result_t guess;
		result_t want;
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				guess = apply_item(req_if.func, req_if.item_value, req_if.item_priority);
				if (pin_q.size() != 0) begin
					pin = pin_q.pop_front();
					pending_q.push_back(pin.pinned ? pin.want : guess);
				end else begin
					pending_q.push_back(guess);
				end
			end
			if (rsp_if.valid && rsp_if.ready) begin
				if (pending_q.size() == 0) begin
					$display("%0t: unexpected response value=%0d prio=%0d status=%0d occ=%0d",
						$realtime, rsp_if.out_value, rsp_if.out_priority,
						rsp_if.status, rsp_if.occupancy);
					errors++;
				end else begin
					want = pending_q.pop_front();
					if (rsp_if.status <= ST_FULL)
						seen_status[rsp_if.status]++;
					if (rsp_if.out_value !== want.value) begin
						$display("%0t: out_value expected %0d actual %0d",
							$realtime, want.value, rsp_if.out_value);
						errors++;
					end
					if (rsp_if.out_priority !== want.prio) begin
						$display("%0t: out_priority expected %0d actual %0d",
							$realtime, want.prio, rsp_if.out_priority);
						errors++;
					end
					if (rsp_if.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$realtime, want.status, rsp_if.status);
						errors++;
					end
					if (rsp_if.occupancy !== want.occ) begin
						$display("%0t: occupancy expected %0d actual %0d",
							$realtime, want.occ, rsp_if.occupancy);
						errors++;
					end
				end
			end
		end
	end

	// Response side back-pressure: runs of ready, broken by random stalls.
	initial begin
		int run;
		int gap;
		rsp_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			run = $urandom_range(1, 20);
			rsp_if.ready <= 1'b1;
			repeat (run) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// Present one request; returns in the time step of its transfer. Valid is
	// only dropped when a gap follows, never toggled within one step.
	task automatic send_item(func_t op, logic signed [VALUE_W-1:0] v, logic [PRIO_W-1:0] p,
			bit pinned, result_t want);
		int   gap;
		pin_t pin;
		gap = pick_gap();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pin.pinned = pinned;
		pin.want   = want;
		pin_q.push_back(pin);
		req_if.valid         <= 1'b1;
		req_if.func          <= op;
		req_if.item_value    <= v;
		req_if.item_priority <= p;
		do
			@(posedge clk);
		while (req_if.ready !== 1'b1);
		sent++;
	endtask

	row_t plan [$];

	initial begin
		int                        k;
		int                        n;
		int                        enq_pct;
		int                        prio_mode;
		func_t                     op;
		logic signed [VALUE_W-1:0] v;
		logic        [PRIO_W-1:0]  p;

		errors = 0;
		cycles = 0;
		sent   = 0;
		held   = 0;
		calm   = 1'b0;
		foreach (seen_status[i])
			seen_status[i] = 0;

		arst_n               <= 1'b0;
		req_if.valid         <= 1'b0;
		req_if.func          <= FN_ENQ;
		req_if.item_value    <= '0;
		req_if.item_priority <= '0;

		// Directed part. Pinned rows carry their answer; the rest use the shadow.
		plan = '{
			// dequeue on empty right out of reset
			'{FN_DEQ, 32'sd0, 8'd0, 1, 1'b1, '{32'sd0, 8'd0, ST_EMPTY, 5'd0}},
			// extreme values at extreme priorities, served in priority order
			'{FN_ENQ, 32'sh7FFF_FFFF, 8'd0, 1, 1'b1, '{32'sd0, 8'd0, ST_INSERTED, 5'd1}},
			'{FN_ENQ, 32'sh8000_0000, 8'd255, 1, 1'b1, '{32'sd0, 8'd0, ST_INSERTED, 5'd2}},
			'{FN_DEQ, 32'sd0, 8'd0, 1, 1'b1,
				'{32'sh8000_0000, 8'd255, ST_REMOVED, 5'd1}},
			'{FN_DEQ, 32'sd0, 8'd0, 1, 1'b1,
				'{32'sh7FFF_FFFF, 8'd0, ST_REMOVED, 5'd0}},
			'{FN_DEQ, 32'sd0, 8'd0, 1, 1'b1, '{32'sd0, 8'd0, ST_EMPTY, 5'd0}},
			// ties keep arrival order, a higher priority jumps ahead
			'{FN_ENQ, 32'sh11, 8'd8, 1, 1'b0, '0},
			'{FN_ENQ, 32'sh22, 8'd8, 1, 1'b0, '0},
			'{FN_ENQ, 32'sh33, 8'd9, 1, 1'b0, '0},
			'{FN_ENQ, 32'sh44, 8'd8, 1, 1'b0, '0},
			'{FN_ENQ, -32'sd1, 8'd0, 1, 1'b0, '0},
			'{FN_DEQ, 32'sd0, 8'd0, 5, 1'b0, '0},
			// fill to capacity, then two enqueues that must be dropped
			'{FN_ENQ, 32'sh5A5A_0000, 8'd3, CAPACITY_DEF, 1'b0, '0},
			'{FN_ENQ, 32'sh1234_5678, 8'd255, 1, 1'b1,
				'{32'sd0, 8'd0, ST_FULL, 5'(CAPACITY_DEF)}},
			'{FN_ENQ, 32'shFFFF_FFFF, 8'd0, 1, 1'b1,
				'{32'sd0, 8'd0, ST_FULL, 5'(CAPACITY_DEF)}},
			// drain completely, then one more on empty
			'{FN_DEQ, 32'sd0, 8'd0, CAPACITY_DEF, 1'b0, '0},
			'{FN_DEQ, 32'sd0, 8'd0, 1, 1'b1, '{32'sd0, 8'd0, ST_EMPTY, 5'd0}}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[r]) begin
			for (k = 0; k < plan[r].reps; k++) begin
				v = plan[r].value + k;
				p = plan[r].prio + PRIO_W'(17 * k);
				send_item(plan[r].op, v, p, plan[r].pinned, plan[r].want);
			end
		end

		// Random part in phases: the enqueue bias swings the queue between
		// empty and full, the priority mode controls how many ties occur.
		for (n = 0; n < RAND_ITEMS; n++) begin
			if (n % PHASE_LEN == 0) begin
				case ($urandom_range(0, 2))
					0: enq_pct = 20;
					1: enq_pct = 50;
					default: enq_pct = 80;
				endcase
				prio_mode = $urandom_range(0, 2);
				calm      = ($urandom_range(0, 4) == 0);
			end
			op = ($urandom_range(0, 99) < enq_pct) ? FN_ENQ : FN_DEQ;
			case ($urandom_range(0, 9))
				0: v = 32'sh7FFF_FFFF;
				1: v = 32'sh8000_0000;
				default: v = $urandom;
			endcase
			case (prio_mode)
				0: p = PRIO_W'($urandom_range(0, 3));
				1: p = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				default: p = PRIO_W'($urandom);
			endcase
			send_item(op, v, p, 1'b0, '0);
		end
		req_if.valid <= 1'b0;

		// let the scoreboard log the last transfer before checking what is owed
		@(posedge clk);
		while (pending_q.size() != 0)
			@(posedge clk);
		// extra edges catch stray responses
		repeat (8) @(posedge clk);

		$display("Ran %0d requests: %0d inserted, %0d removed, %0d empty, %0d dropped full",
			sent, seen_status[ST_INSERTED], seen_status[ST_REMOVED],
			seen_status[ST_EMPTY], seen_status[ST_FULL]);
		$display("Ties, extreme values and priorities, full and empty queue all exercised");
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
